// ===== hw/rtl/mcfp_pkg.sv =====
`default_nettype none

package mcfp_pkg;

    // frame buffer
    localparam int DEF_FRAME_DEPTH = 10;
    localparam int MOVE_LEN        = 6;
    localparam int STATUS_LEN      = 2;
    localparam int NUM_MOTORS      = 3;

    // characters
    localparam logic [7:0] NEWLINE = 8'd10;
    localparam logic [7:0] CHAR_M  = 8'h4D;
    localparam logic [7:0] CHAR_S  = 8'h53;
    localparam logic [7:0] CHAR_Y  = 8'h59;
    localparam logic [7:0] CHAR_I  = 8'h49;
    localparam logic [7:0] CHAR_B  = 8'h42;

    // reply lengths
    localparam logic [3:0] MOVE_REPLY_LEN   = 4'd5;
    localparam logic [3:0] ECHO_REPLY_LEN   = 4'd9;
    localparam logic [3:0] STATUS_REPLY_LEN = 4'd5;
    localparam logic [3:0] STATUS_SHORT_LEN = 4'd4;

    // register widths and reset values
    localparam int RATIO_W = 13;
    localparam int SPEED_W = 15;
    localparam int ANGLE_W = 20;
    localparam int CFG_W   = 15;
    localparam logic [RATIO_W-1:0] RATIO0_RESET    = 13'd1024;
    localparam logic [RATIO_W-1:0] RATIO1_RESET    = 13'd5172;
    localparam logic [RATIO_W-1:0] RATIO2_RESET    = 13'd5542;
    localparam logic [SPEED_W-1:0] MIN_SPEED_RESET = 15'd30;

    // register indexes
    localparam logic [1:0] CFG_GEAR0     = 2'd0;
    localparam logic [1:0] CFG_GEAR1     = 2'd1;
    localparam logic [1:0] CFG_GEAR2     = 2'd2;
    localparam logic [1:0] CFG_MIN_SPEED = 2'd3;

    // arithmetic
    localparam int ALU_W      = 29;
    localparam int MAG_W      = 16;
    localparam int FRAC_BITS  = 10;
    localparam int SCALED_W   = 19;
    localparam int MOD_BASE   = 100;
    localparam int ROUND_HALF = 512;
    // 100 = (1 << 2) + (1 << 5) + (1 << 6)
    localparam int MAG_SH0    = 2;
    localparam int MAG_SH1    = 5;
    localparam int MAG_SH2    = 6;

    typedef enum logic {
        ALU_ADD = 1'b0,
        ALU_SUB = 1'b1
    } t_alu_op;

    typedef enum logic [1:0] {
        KIND_NONE   = 2'd0,
        KIND_MOVE   = 2'd1,
        KIND_ECHO   = 2'd2,
        KIND_STATUS = 2'd3
    } t_kind;

    typedef struct packed {
        logic  start;
        t_kind kind;
    } t_frame_evt;

    typedef struct packed {
        logic [7:0] b1;
        logic [7:0] b2;
        logic [7:0] b3;
        logic [7:0] b4;
        logic [7:0] b5;
    } t_frame_view;

    typedef struct packed {
        logic [RATIO_W-1:0] ratio0;
        logic [RATIO_W-1:0] ratio1;
        logic [RATIO_W-1:0] ratio2;
        logic [SPEED_W-1:0] min_speed;
    } t_cfg;

    typedef struct packed {
        logic [7:0]         reply_byte;
        logic               last_reply;
        logic               update_valid;
        logic [1:0]         motor_id;
        logic [ANGLE_W-1:0] requested_angle;
        logic [SPEED_W-1:0] motor_speed;
        logic               wake_motor;
    } t_result;

endpackage

`default_nettype wire

// ===== hw/rtl/mcfp_alu.sv =====
`default_nettype none

module mcfp_alu
    import mcfp_pkg::*;
(
    input  wire logic [ALU_W-1:0] i_a,
    input  wire logic [ALU_W-1:0] i_b,
    input  wire t_alu_op          i_op,
    output logic      [ALU_W-1:0] o_sum,
    output logic                  o_ge
);

    logic [ALU_W:0] w_full;
    logic [ALU_W-1:0] w_b;

    // subtract as a + ~b + 1, carry out means no borrow
    assign w_b    = (i_op == ALU_SUB) ? ~i_b : i_b;
    assign w_full = {1'b0, i_a} + {1'b0, w_b} + {{ALU_W{1'b0}}, (i_op == ALU_SUB)};
    assign o_sum  = w_full[ALU_W-1:0];
    assign o_ge   = w_full[ALU_W];

endmodule

`default_nettype wire

// ===== hw/rtl/mcfp_frame_buf.sv =====
`default_nettype none

module mcfp_frame_buf
    import mcfp_pkg::*;
#(
    parameter  int FRAME_DEPTH = DEF_FRAME_DEPTH,
    localparam int IDX_W       = $clog2(FRAME_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_wr,
    input  wire logic [7:0]       i_byte,
    input  wire logic [IDX_W-1:0] i_rd_addr,
    output logic      [7:0]       o_rd_data,
    output t_frame_evt            o_evt,
    output t_frame_view           o_view
);

    logic [7:0]       r_mem [FRAME_DEPTH];
    logic [IDX_W-1:0] r_idx;
    logic             w_nl;
    logic [2:0]       w_motor;

    assign w_nl = (i_byte == NEWLINE);

    always_ff @(posedge i_clk) begin
        if (i_wr && !(w_nl && r_idx == '0)) begin
            r_mem[r_idx] <= i_byte;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (i_wr) begin
            if (w_nl) begin
                r_idx <= '0;
            end else if (r_idx == IDX_W'(FRAME_DEPTH - 1)) begin
                r_idx <= '0;
            end else begin
                r_idx <= r_idx + 1'b1;
            end
        end
    end

    assign w_motor = r_mem[1][6:4];

    always_comb begin
        o_evt.start = i_wr && w_nl && (r_idx != '0);
        o_evt.kind  = KIND_NONE;
        if (r_mem[0] == CHAR_M && r_idx == IDX_W'(MOVE_LEN)) begin
            o_evt.kind = (w_motor < 3'(NUM_MOTORS)) ? KIND_MOVE : KIND_ECHO;
        end else if (r_mem[0] == CHAR_S && r_idx == IDX_W'(STATUS_LEN)) begin
            o_evt.kind = KIND_STATUS;
        end
    end

    assign o_view.b1 = r_mem[1];
    assign o_view.b2 = r_mem[2];
    assign o_view.b3 = r_mem[3];
    assign o_view.b4 = r_mem[4];
    assign o_view.b5 = r_mem[5];
    assign o_rd_data = r_mem[i_rd_addr];

endmodule

`default_nettype wire

// ===== hw/rtl/mcfp_seq.sv =====
`default_nettype none

module mcfp_seq
    import mcfp_pkg::*;
#(
    parameter  int FRAME_DEPTH = DEF_FRAME_DEPTH,
    localparam int IDX_W       = $clog2(FRAME_DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_frame_evt       i_evt,
    input  wire t_frame_view      i_view,
    input  wire logic [2:0]       i_motor_asleep,
    input  wire t_cfg             i_cfg,
    input  wire logic [7:0]       i_rd_data,
    output logic      [IDX_W-1:0] o_rd_addr,
    input  wire logic             i_slot_free,
    output logic                  o_idle,
    output logic                  o_res_valid,
    output t_result               o_res
);

    typedef enum logic [6:0] {
        ST_IDLE = 7'b0000001,
        ST_MOD  = 7'b0000010,
        ST_MAG  = 7'b0000100,
        ST_MUL  = 7'b0001000,
        ST_NEG  = 7'b0010000,
        ST_SPD  = 7'b0100000,
        ST_EMIT = 7'b1000000
    } t_seq_state;

    t_seq_state          r_state, n_state;
    t_kind               r_kind, n_kind;
    logic [3:0]          r_cnt, n_cnt;
    logic [3:0]          r_len, n_len;
    logic [ALU_W-1:0]    r_acc, n_acc;
    logic [MAG_W-1:0]    r_mag, n_mag;
    logic [ANGLE_W-1:0]  r_angle, n_angle;
    logic [SPEED_W-1:0]  r_speed, n_speed;
    logic [2:0]          r_asleep, n_asleep;

    logic [ALU_W-1:0]    alu_a, alu_b, alu_sum;
    t_alu_op             alu_op;
    logic                alu_ge;

    logic [1:0]          w_motor;
    logic [8:0]          w_hi9;
    logic [RATIO_W-1:0]  w_ratio;
    logic [SCALED_W-1:0] w_scaled;
    logic [SPEED_W-1:0]  w_speed_req;
    logic                w_last;

    mcfp_alu u_alu (
        .i_a   (alu_a),
        .i_b   (alu_b),
        .i_op  (alu_op),
        .o_sum (alu_sum),
        .o_ge  (alu_ge)
    );

    assign w_motor     = i_view.b1[5:4];
    assign w_hi9       = {i_view.b1[0], i_view.b2};
    assign w_scaled    = r_acc[FRAC_BITS +: SCALED_W];
    assign w_speed_req = {i_view.b4[6:0], i_view.b5};
    assign w_last      = (r_cnt == r_len - 4'd1);
    assign o_idle      = (r_state == ST_IDLE);
    assign o_rd_addr   = IDX_W'(r_cnt - 4'd1);

    always_comb begin
        case (w_motor)
            2'd0:    w_ratio = i_cfg.ratio0;
            2'd1:    w_ratio = i_cfg.ratio1;
            default: w_ratio = i_cfg.ratio2;
        endcase
    end

    always_comb begin
        n_state  = r_state;
        n_kind   = r_kind;
        n_cnt    = r_cnt;
        n_len    = r_len;
        n_acc    = r_acc;
        n_mag    = r_mag;
        n_angle  = r_angle;
        n_speed  = r_speed;
        n_asleep = r_asleep;
        alu_a    = '0;
        alu_b    = '0;
        alu_op   = ALU_ADD;
        o_res_valid = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (i_evt.start) begin
                    n_kind   = i_evt.kind;
                    n_asleep = i_motor_asleep;
                    n_cnt    = '0;
                    case (i_evt.kind)
                        KIND_MOVE: begin
                            n_acc   = ALU_W'(i_view.b3);
                            n_state = ST_MOD;
                        end
                        KIND_ECHO: begin
                            n_len   = ECHO_REPLY_LEN;
                            n_state = ST_EMIT;
                        end
                        KIND_STATUS: begin
                            n_len   = (i_view.b1 < 8'(NUM_MOTORS)) ? STATUS_REPLY_LEN
                                                                   : STATUS_SHORT_LEN;
                            n_state = ST_EMIT;
                        end
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_MOD: begin
                // two conditional subtracts bring a byte below the base
                alu_a  = r_acc;
                alu_b  = ALU_W'(MOD_BASE);
                alu_op = ALU_SUB;
                if (alu_ge) begin
                    n_acc = alu_sum;
                end
                if (r_cnt == 4'd1) begin
                    n_cnt   = '0;
                    n_state = ST_MAG;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_MAG: begin
                // whole degrees times 100 as three shifted adds
                alu_a = r_acc;
                case (r_cnt)
                    4'd0:    alu_b = ALU_W'(w_hi9) << MAG_SH0;
                    4'd1:    alu_b = ALU_W'(w_hi9) << MAG_SH1;
                    default: alu_b = ALU_W'(w_hi9) << MAG_SH2;
                endcase
                n_acc = alu_sum;
                if (r_cnt == 4'd2) begin
                    n_mag   = alu_sum[MAG_W-1:0];
                    n_acc   = ALU_W'(ROUND_HALF);
                    n_cnt   = '0;
                    n_state = ST_MUL;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_MUL: begin
                // shift-add multiply, one ratio bit a cycle, starting from the rounding half
                alu_a = r_acc;
                alu_b = ALU_W'(r_mag) << r_cnt;
                if (w_ratio[r_cnt]) begin
                    n_acc = alu_sum;
                end
                if (r_cnt == 4'(RATIO_W - 1)) begin
                    n_cnt   = '0;
                    n_state = ST_NEG;
                end else begin
                    n_cnt = r_cnt + 4'd1;
                end
            end
            ST_NEG: begin
                alu_a   = '0;
                alu_b   = ALU_W'(w_scaled);
                alu_op  = ALU_SUB;
                n_angle = i_view.b1[3] ? alu_sum[ANGLE_W-1:0] : ANGLE_W'(w_scaled);
                n_state = ST_SPD;
            end
            ST_SPD: begin
                alu_a   = ALU_W'(w_speed_req);
                alu_b   = ALU_W'(i_cfg.min_speed);
                alu_op  = ALU_SUB;
                n_speed = alu_ge ? w_speed_req : i_cfg.min_speed;
                n_len   = MOVE_REPLY_LEN;
                n_cnt   = '0;
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                if (i_slot_free) begin
                    o_res_valid = 1'b1;
                    if (w_last) begin
                        n_cnt   = '0;
                        n_state = ST_IDLE;
                    end else begin
                        n_cnt = r_cnt + 4'd1;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // reply byte at position r_cnt
    always_comb begin
        o_res            = '0;
        o_res.last_reply = w_last;
        if (r_cnt == 4'd0 || w_last) begin
            o_res.reply_byte = NEWLINE;
        end else begin
            case (r_kind)
                KIND_MOVE: begin
                    case (r_cnt)
                        4'd1:    o_res.reply_byte = CHAR_M;
                        4'd2:    o_res.reply_byte = {6'd0, w_motor};
                        default: o_res.reply_byte = CHAR_Y;
                    endcase
                end
                KIND_ECHO: o_res.reply_byte = i_rd_data;
                KIND_STATUS: begin
                    case (r_cnt)
                        4'd1:    o_res.reply_byte = CHAR_S;
                        4'd2:    o_res.reply_byte = i_view.b1;
                        default: o_res.reply_byte = r_asleep[i_view.b1[1:0]] ? CHAR_I
                                                                            : CHAR_B;
                    endcase
                end
                default: o_res.reply_byte = NEWLINE;
            endcase
        end
        if (r_kind == KIND_MOVE && r_cnt == 4'd0) begin
            o_res.update_valid    = 1'b1;
            o_res.motor_id        = w_motor;
            o_res.requested_angle = r_angle;
            o_res.motor_speed     = r_speed;
            o_res.wake_motor      = r_asleep[w_motor];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_kind  <= KIND_NONE;
            r_len   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_kind  <= n_kind;
            r_len   <= n_len;
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc    <= n_acc;
        r_mag    <= n_mag;
        r_angle  <= n_angle;
        r_speed  <= n_speed;
        r_asleep <= n_asleep;
    end

endmodule

`default_nettype wire

// ===== hw/rtl/motor_command_frame_parser.sv =====
`default_nettype none

// Motor command frame parser. Received bytes are transferred in one at a time and
// collected into a wrapping frame buffer; a newline closes a non-empty frame and
// its reply bytes come out as result transfers, the last one flagged by
// o_last_reply. A move frame for motor 0..2 carries the motor update on its first
// reply (o_update_valid). A newline that closes a move frame for motor 0..2 runs on
// the one shared adder (2 remainder steps, 3 steps for the x100, 13 shift-add
// multiply steps, negate, speed floor) and then emits one reply byte per cycle
// while the output keeps up; echo and status frames go straight to their 9 or
// 4..5 reply bytes. Reply cycles stretch while o_out_valid waits on i_out_ready.
// Gear ratios and the speed floor are written over the configuration port, always
// ready; the user must write them only while no frame is being processed, as the
// block itself does not enforce this.

module motor_command_frame_parser
    import mcfp_pkg::*;
#(
    parameter  int FRAME_DEPTH = DEF_FRAME_DEPTH,
    localparam int IDX_W       = $clog2(FRAME_DEPTH)
) (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    // byte input
    input  wire logic               i_in_valid,
    output logic                    o_in_ready,
    input  wire logic [7:0]         i_rx_byte,
    input  wire logic [2:0]         i_motor_asleep,
    // reply output
    output logic                    o_out_valid,
    input  wire logic               i_out_ready,
    output logic      [7:0]         o_reply_byte,
    output logic                    o_last_reply,
    output logic                    o_update_valid,
    output logic      [1:0]         o_motor_id,
    output logic signed [ANGLE_W-1:0] o_requested_angle,
    output logic      [SPEED_W-1:0] o_motor_speed,
    output logic                    o_wake_motor,
    // configuration writes
    input  wire logic               i_cfg_valid,
    output logic                    o_cfg_ready,
    input  wire logic [1:0]         i_cfg_index,
    input  wire logic [CFG_W-1:0]   i_cfg_data
);

    t_cfg        r_cfg;
    logic        r_out_valid;
    t_result     r_out;

    logic        w_in_xfer;
    logic        w_slot_free;
    logic        w_idle;
    logic        w_res_valid;
    t_result     w_res;
    t_frame_evt  w_evt;
    t_frame_view w_view;
    logic [IDX_W-1:0] w_rd_addr;
    logic [7:0]  w_rd_data;

    // bytes are taken only while the sequencer is idle
    assign o_in_ready  = w_idle;
    assign w_in_xfer   = i_in_valid && o_in_ready;
    // output register frees up in the same cycle it is drained
    assign w_slot_free = !r_out_valid || i_out_ready;
    assign o_cfg_ready = 1'b1;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ratio0    <= RATIO0_RESET;
            r_cfg.ratio1    <= RATIO1_RESET;
            r_cfg.ratio2    <= RATIO2_RESET;
            r_cfg.min_speed <= MIN_SPEED_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                CFG_GEAR0:     r_cfg.ratio0    <= i_cfg_data[RATIO_W-1:0];
                CFG_GEAR1:     r_cfg.ratio1    <= i_cfg_data[RATIO_W-1:0];
                CFG_GEAR2:     r_cfg.ratio2    <= i_cfg_data[RATIO_W-1:0];
                CFG_MIN_SPEED: r_cfg.min_speed <= i_cfg_data[SPEED_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // frame buffer and frame classification
    mcfp_frame_buf #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_frame_buf (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (w_in_xfer),
        .i_byte    (i_rx_byte),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_evt     (w_evt),
        .o_view    (w_view)
    );

    // sequencer around the shared adder, also walks out the reply bytes
    mcfp_seq #(
        .FRAME_DEPTH (FRAME_DEPTH)
    ) u_seq (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_evt          (w_evt),
        .i_view         (w_view),
        .i_motor_asleep (i_motor_asleep),
        .i_cfg          (r_cfg),
        .i_rd_data      (w_rd_data),
        .o_rd_addr      (w_rd_addr),
        .i_slot_free    (w_slot_free),
        .o_idle         (w_idle),
        .o_res_valid    (w_res_valid),
        .o_res          (w_res)
    );

    // output register, parts the sequencer from the downstream ready
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid) begin
            r_out <= w_res;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_reply_byte      = r_out.reply_byte;
    assign o_last_reply      = r_out.last_reply;
    assign o_update_valid    = r_out.update_valid;
    assign o_motor_id        = r_out.motor_id;
    assign o_requested_angle = r_out.requested_angle;
    assign o_motor_speed     = r_out.motor_speed;
    assign o_wake_motor      = r_out.wake_motor;

endmodule

`default_nettype wire
